@@ rtl/fuzzy_sync_frame_deframer_top_macros.svh @@
// Assertion macros for the sync frame deframer
`ifndef FUZZY_SYNC_FRAME_DEFRAMER_TOP_MACROS_SVH
`define FUZZY_SYNC_FRAME_DEFRAMER_TOP_MACROS_SVH
`ifndef NO_ASSERTIONS
`define FSFD_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("fsfd: same-cycle check failed");
`define FSFD_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("fsfd: next-cycle check failed");
`else
`define FSFD_ASSERT_IMP(lbl, ante, cons)
`define FSFD_ASSERT_NXT(lbl, ante, cons)
`endif
`endif

@@ rtl/fsfd_pkg.sv @@
// Shared types, codes and helpers for the sync frame deframer
`timescale 1ns / 1ps
package fsfd_pkg;

    typedef struct packed {
        logic link;
        logic stream;
        logic eot;
    } match_t;

    typedef struct packed {
        logic put;
        logic preload;
        logic skip_clear;
        logic start;
    } store_ctl_t;

    localparam logic [2:0] CFG_LINK_SYNC   = 3'd0;
    localparam logic [2:0] CFG_STREAM_SYNC = 3'd1;
    localparam logic [2:0] CFG_EOT_SYNC    = 3'd2;
    localparam logic [2:0] CFG_START_LIMIT = 3'd3;
    localparam logic [2:0] CFG_RUN_LIMIT   = 3'd4;
    localparam logic [2:0] CFG_BUDGET      = 3'd5;

    localparam logic [15:0] LINK_SYNC_RST   = 16'd22007;
    localparam logic [15:0] STREAM_SYNC_RST = 16'd65373;
    localparam logic [15:0] EOT_SYNC_RST    = 16'd21853;
    localparam logic [4:0]  START_LIMIT_RST = 5'd0;
    localparam logic [4:0]  RUN_LIMIT_RST   = 5'd2;
    localparam logic [3:0]  BUDGET_RST      = 4'd4;

    localparam logic [1:0] EV_BYTE = 2'd0;
    localparam logic [1:0] EV_SYNC = 2'd1;
    localparam logic [1:0] EV_EOT  = 2'd2;
    localparam logic [1:0] EV_LOST = 2'd3;

    function automatic logic [4:0] ones16(input logic [15:0] v);
        logic [2:0] nib [4];
        for (int i = 0; i < 4; i++)
        begin
            nib[i] = 3'(v[4*i]) + 3'(v[4*i+1]) + 3'(v[4*i+2]) + 3'(v[4*i+3]);
        end
        return 5'(nib[0]) + 5'(nib[1]) + 5'(nib[2]) + 5'(nib[3]);
    endfunction

endpackage

@@ rtl/fsfd_correlator.sv @@
// Sync window shift register and fuzzy matchers for the three sync words
`timescale 1ns / 1ps
module fsfd_correlator #(
    parameter int SYNC_BITS = 16
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                shift,
    input  logic                clear,
    input  logic                rx_bit,
    input  logic [15:0]         link_word,
    input  logic [15:0]         stream_word,
    input  logic [15:0]         eot_word,
    input  logic [4:0]          limit,
    output fsfd_pkg::match_t    hit
);

    logic [SYNC_BITS-1:0] window_reg;
    logic [SYNC_BITS-1:0] window_next;
    logic [15:0]          link_diff;
    logic [15:0]          stream_diff;
    logic [15:0]          eot_diff;

    assign window_next = {window_reg[SYNC_BITS-2:0], rx_bit};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            window_reg <= '0;
        end
        else if (clear)
        begin
            window_reg <= '0;
        end
        else if (shift)
        begin
            window_reg <= window_next;
        end
    end

    assign link_diff   = 16'(window_next ^ link_word[SYNC_BITS-1:0]);
    assign stream_diff = 16'(window_next ^ stream_word[SYNC_BITS-1:0]);
    assign eot_diff    = 16'(window_next ^ eot_word[SYNC_BITS-1:0]);

    assign hit.link   = fsfd_pkg::ones16(link_diff) <= limit;
    assign hit.stream = fsfd_pkg::ones16(stream_diff) <= limit;
    assign hit.eot    = fsfd_pkg::ones16(eot_diff) <= limit;

endmodule

@@ rtl/fsfd_frame_store.sv @@
// Frame store: head bytes in flops, bit accumulator into a byte memory, readout
`timescale 1ns / 1ps
module fsfd_frame_store #(
    parameter int FRAME_BITS = 384,
    parameter int SYNC_BITS  = 16
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  fsfd_pkg::store_ctl_t                ctl,
    input  logic [$clog2(FRAME_BITS+1)-1:0]     pos,
    input  logic                                rx_bit,
    input  logic [15:0]                         sync_word,
    input  logic                                rd_take,
    output logic                                rd_valid,
    output logic [7:0]                          rd_data,
    output logic [5:0]                          rd_index,
    output logic                                rd_last
);

    localparam int FRAME_BYTES = (FRAME_BITS + 7) / 8;
    localparam int HEAD_BITS   = ((SYNC_BITS + 9) / 8) * 8;
    localparam int HEAD_BYTES  = HEAD_BITS / 8;
    localparam int PTR_W       = $clog2(FRAME_BITS + 1);
    localparam int ADDR_W      = $clog2(FRAME_BYTES);
    localparam int CNT_W       = $clog2(FRAME_BYTES + 1);
    localparam int HB_W        = $clog2(HEAD_BYTES);
    localparam int SKIP_BYTE   = (SYNC_BITS - 1) / 8;
    localparam int SKIP_BIT    = 7 - ((SYNC_BITS - 1) % 8);

    logic [7:0]           head_reg [HEAD_BYTES];
    logic [7:0]           mem [FRAME_BYTES];
    logic [7:0]           acc_reg;
    logic [7:0]           acc_next;
    logic [HEAD_BITS-1:0] preload_bits;
    logic                 in_head;
    logic                 byte_done;
    logic [HB_W-1:0]      head_sel;
    logic [2:0]           bit_sel;

    logic [CNT_W-1:0]     issue_reg;
    logic                 q_valid_reg;
    logic [ADDR_W-1:0]    q_idx_reg;
    logic                 head_hit_reg;
    logic [7:0]           head_q_reg;
    logic [7:0]           mem_q_reg;
    logic                 rd_en;

    assign preload_bits = {sync_word[SYNC_BITS-1:0], {(HEAD_BITS-SYNC_BITS){1'b0}}};
    assign in_head      = pos < PTR_W'(HEAD_BITS);
    assign head_sel     = pos[HB_W+2:3];
    assign bit_sel      = 3'd7 - pos[2:0];
    assign acc_next     = {acc_reg[6:0], rx_bit};
    assign byte_done    = (pos[2:0] == 3'd7) || (pos == PTR_W'(FRAME_BITS - 1));

    always_ff @(posedge clk)
    begin
        if (ctl.preload)
        begin
            for (int i = 0; i < HEAD_BYTES; i++)
            begin
                head_reg[i] <= preload_bits[HEAD_BITS-1-8*i -: 8];
            end
        end
        else
        begin
            if (ctl.put && in_head)
            begin
                head_reg[head_sel][bit_sel] <= rx_bit;
            end
            if (ctl.skip_clear)
            begin
                head_reg[HB_W'(SKIP_BYTE)][3'(SKIP_BIT)] <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.put)
        begin
            acc_reg <= acc_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.put && !in_head && byte_done)
        begin
            mem[pos[ADDR_W+2:3]] <= acc_next << bit_sel;
        end
    end

    assign rd_en = (issue_reg < CNT_W'(FRAME_BYTES)) && (!q_valid_reg || rd_take);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            issue_reg   <= CNT_W'(FRAME_BYTES);
            q_valid_reg <= 1'b0;
        end
        else
        begin
            if (ctl.start)
            begin
                issue_reg <= '0;
            end
            else if (rd_en)
            begin
                issue_reg <= issue_reg + CNT_W'(1);
            end

            if (rd_en)
            begin
                q_valid_reg <= 1'b1;
            end
            else if (rd_take)
            begin
                q_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            q_idx_reg    <= issue_reg[ADDR_W-1:0];
            head_hit_reg <= issue_reg < CNT_W'(HEAD_BYTES);
            head_q_reg   <= head_reg[issue_reg[HB_W-1:0]];
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            mem_q_reg <= mem[issue_reg[ADDR_W-1:0]];
        end
    end

    assign rd_valid = q_valid_reg;
    assign rd_data  = head_hit_reg ? head_q_reg : mem_q_reg;
    assign rd_index = 6'(q_idx_reg);
    assign rd_last  = q_idx_reg == ADDR_W'(FRAME_BYTES - 1);

endmodule

@@ rtl/fuzzy_sync_frame_deframer_top.sv @@
// Top level of the sync frame deframer: control, configuration and output register
`timescale 1ns / 1ps
`include "fuzzy_sync_frame_deframer_top_macros.svh"
// One received bit is taken per clock cycle while hunting or receiving and the
// input is not stalled; it shifts through the sync window and, once locked,
// into the frame store one bit per cycle while not stalled. Sync acquired, end of
// transmission and lock lost each give one transaction on the output and hold
// input only while the output register is stalled. A completed frame is read out
// from the store one byte per cycle unless the output stalls, through a registered
// memory read port: FRAME_BITS/8 rounded up transactions (48 by default), during
// which no input bit is accepted. The first HEAD_BITS/8 bytes (3 by default) of a
// frame sit in flops so that sync realignment can rewrite them; the rest reach
// the memory through an 8-bit accumulator. No clearing pass runs after reset.
module fuzzy_sync_frame_deframer_top #(
    parameter int FRAME_BITS = 384,
    parameter int SYNC_BITS  = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic        cmd,
    input  logic        rx_bit,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [1:0]  event_kind,
    output logic        frame_type,
    output logic [7:0]  data_byte,
    output logic [5:0]  byte_index,
    output logic        sync_seen,
    output logic        last,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [15:0] cfg_data
);

    localparam int FRAME_BYTES = (FRAME_BITS + 7) / 8;
    localparam int PTR_W       = $clog2(FRAME_BITS + 1);

    localparam logic [1:0] MODE_HUNT   = 2'd0;
    localparam logic [1:0] MODE_LINK   = 2'd1;
    localparam logic [1:0] MODE_STREAM = 2'd2;

    logic [15:0] link_reg;
    logic [15:0] stream_reg;
    logic [15:0] eot_reg;
    logic [4:0]  start_lim_reg;
    logic [4:0]  run_lim_reg;
    logic [3:0]  budget_reg;

    logic [1:0]       mode_reg;
    logic [1:0]       mode_next;
    logic [PTR_W-1:0] ptr_reg;
    logic [PTR_W-1:0] ptr_next;
    logic [PTR_W-1:0] ptr_inc;
    logic [3:0]       lost_reg;
    logic [3:0]       lost_next;
    logic [3:0]       lost_dec;
    logic             ro_active_reg;
    logic             ro_active_next;
    logic             ro_type_reg;
    logic             ro_type_next;
    logic             ro_seen_reg;
    logic             ro_seen_next;

    logic             out_valid_reg;
    logic [1:0]       event_kind_reg;
    logic             frame_type_reg;
    logic [7:0]       data_byte_reg;
    logic [5:0]       byte_index_reg;
    logic             sync_seen_reg;
    logic             last_reg;

    logic             accept;
    logic             bit_acc;
    logic             locked;
    logic             cur_type;
    logic             zone;
    logic             frame_end;
    logic [4:0]       limit;
    logic             win_clear;
    logic [15:0]      preload_word;
    logic             ev_load;
    logic [1:0]       ev_kind;
    logic             ev_type;
    logic             out_free;
    logic             rd_take;
    logic             rd_valid;
    logic [7:0]       rd_data;
    logic [5:0]       rd_index;
    logic             rd_last;

    fsfd_pkg::match_t     hit;
    fsfd_pkg::store_ctl_t store_ctl;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            link_reg      <= fsfd_pkg::LINK_SYNC_RST;
            stream_reg    <= fsfd_pkg::STREAM_SYNC_RST;
            eot_reg       <= fsfd_pkg::EOT_SYNC_RST;
            start_lim_reg <= fsfd_pkg::START_LIMIT_RST;
            run_lim_reg   <= fsfd_pkg::RUN_LIMIT_RST;
            budget_reg    <= fsfd_pkg::BUDGET_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                fsfd_pkg::CFG_LINK_SYNC:   link_reg      <= cfg_data;
                fsfd_pkg::CFG_STREAM_SYNC: stream_reg    <= cfg_data;
                fsfd_pkg::CFG_EOT_SYNC:    eot_reg       <= cfg_data;
                fsfd_pkg::CFG_START_LIMIT: start_lim_reg <= cfg_data[4:0];
                fsfd_pkg::CFG_RUN_LIMIT:   run_lim_reg   <= cfg_data[4:0];
                fsfd_pkg::CFG_BUDGET:      budget_reg    <= cfg_data[3:0];
                default:                   ;
            endcase
        end
    end

    assign out_free = !out_valid_reg || !out_stall;
    assign in_stall = ro_active_reg || !out_free;
    assign accept   = in_valid && !in_stall;
    assign bit_acc  = accept && !cmd;
    assign locked   = (mode_reg == MODE_LINK) || (mode_reg == MODE_STREAM);
    assign cur_type = mode_reg == MODE_STREAM;
    assign limit    = locked ? run_lim_reg : start_lim_reg;
    assign ptr_inc  = ptr_reg + PTR_W'(1);
    assign lost_dec = lost_reg - 4'd1;
    assign zone     = (ptr_inc >= PTR_W'(SYNC_BITS - 1)) && (ptr_inc <= PTR_W'(SYNC_BITS + 1));
    assign frame_end    = ptr_inc >= PTR_W'(FRAME_BITS);
    assign preload_word = hit.link ? link_reg : stream_reg;
    assign rd_take      = rd_valid && out_free;

    fsfd_correlator #(
        .SYNC_BITS (SYNC_BITS)
    ) u_corr (
        .clk         (clk),
        .rst_n       (rst_n),
        .shift       (bit_acc),
        .clear       (win_clear),
        .rx_bit      (rx_bit),
        .link_word   (link_reg),
        .stream_word (stream_reg),
        .eot_word    (eot_reg),
        .limit       (limit),
        .hit         (hit)
    );

    fsfd_frame_store #(
        .FRAME_BITS (FRAME_BITS),
        .SYNC_BITS  (SYNC_BITS)
    ) u_store (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctl       (store_ctl),
        .pos       (ptr_reg),
        .rx_bit    (rx_bit),
        .sync_word (preload_word),
        .rd_take   (rd_take),
        .rd_valid  (rd_valid),
        .rd_data   (rd_data),
        .rd_index  (rd_index),
        .rd_last   (rd_last)
    );

    always_comb
    begin
        mode_next      = mode_reg;
        ptr_next       = ptr_reg;
        lost_next      = lost_reg;
        ro_active_next = ro_active_reg;
        ro_type_next   = ro_type_reg;
        ro_seen_next   = ro_seen_reg;
        win_clear      = 1'b0;
        ev_load        = 1'b0;
        ev_kind        = fsfd_pkg::EV_SYNC;
        ev_type        = 1'b0;
        store_ctl      = '0;

        if (rd_take && rd_last)
        begin
            ro_active_next = 1'b0;
        end

        if (accept && cmd)
        begin
            mode_next = MODE_HUNT;
            ptr_next  = '0;
            lost_next = 4'd0;
            win_clear = 1'b1;
        end
        else if (bit_acc && !locked)
        begin
            if (hit.link || hit.stream)
            begin
                store_ctl.preload = 1'b1;
                lost_next = budget_reg;
                ptr_next  = PTR_W'(SYNC_BITS);
                mode_next = hit.link ? MODE_LINK : MODE_STREAM;
                ev_load   = 1'b1;
                ev_kind   = fsfd_pkg::EV_SYNC;
                ev_type   = !hit.link;
            end
        end
        else if (bit_acc)
        begin
            store_ctl.put = 1'b1;
            ptr_next = ptr_inc;
            if (zone && (hit.link || hit.stream))
            begin
                lost_next = budget_reg;
                ptr_next  = PTR_W'(SYNC_BITS);
                mode_next = hit.link ? MODE_LINK : MODE_STREAM;
                store_ctl.skip_clear = ptr_inc == PTR_W'(SYNC_BITS - 1);
            end
            else if (zone && hit.eot)
            begin
                mode_next = MODE_HUNT;
                ptr_next  = '0;
                lost_next = 4'd0;
                win_clear = 1'b1;
                ev_load   = 1'b1;
                ev_kind   = fsfd_pkg::EV_EOT;
                ev_type   = cur_type;
            end
            else if (frame_end)
            begin
                lost_next = lost_dec;
                ptr_next  = '0;
                if (lost_dec == 4'd0)
                begin
                    mode_next = MODE_HUNT;
                    win_clear = 1'b1;
                    ev_load   = 1'b1;
                    ev_kind   = fsfd_pkg::EV_LOST;
                    ev_type   = cur_type;
                end
                else
                begin
                    store_ctl.start = 1'b1;
                    ro_active_next  = 1'b1;
                    ro_type_next    = cur_type;
                    ro_seen_next    = lost_dec == (budget_reg - 4'd1);
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg      <= MODE_HUNT;
            ptr_reg       <= '0;
            lost_reg      <= 4'd0;
            ro_active_reg <= 1'b0;
            ro_type_reg   <= 1'b0;
            ro_seen_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            mode_reg      <= mode_next;
            ptr_reg       <= ptr_next;
            lost_reg      <= lost_next;
            ro_active_reg <= ro_active_next;
            ro_type_reg   <= ro_type_next;
            ro_seen_reg   <= ro_seen_next;
            if (ev_load || rd_take)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ev_load)
        begin
            event_kind_reg <= ev_kind;
            frame_type_reg <= ev_type;
            data_byte_reg  <= 8'd0;
            byte_index_reg <= 6'd0;
            sync_seen_reg  <= 1'b0;
            last_reg       <= 1'b1;
        end
        else if (rd_take)
        begin
            event_kind_reg <= fsfd_pkg::EV_BYTE;
            frame_type_reg <= ro_type_reg;
            data_byte_reg  <= rd_data;
            byte_index_reg <= rd_index;
            sync_seen_reg  <= ro_seen_reg;
            last_reg       <= rd_last;
        end
    end

    assign out_valid  = out_valid_reg;
    assign event_kind = event_kind_reg;
    assign frame_type = frame_type_reg;
    assign data_byte  = data_byte_reg;
    assign byte_index = byte_index_reg;
    assign sync_seen  = sync_seen_reg;
    assign last       = last_reg;

    `FSFD_ASSERT_IMP(a_hunt_idle, mode_reg == MODE_HUNT, ptr_reg == '0 && lost_reg == 4'd0)
    `FSFD_ASSERT_IMP(a_ro_locked, ro_active_reg, mode_reg == MODE_LINK || mode_reg == MODE_STREAM)
    `FSFD_ASSERT_IMP(a_ptr_range, locked, ptr_reg < PTR_W'(FRAME_BITS))
    `FSFD_ASSERT_IMP(a_last_byte, out_valid_reg && event_kind_reg == fsfd_pkg::EV_BYTE && last_reg, byte_index_reg == 6'(FRAME_BYTES - 1))
    `FSFD_ASSERT_NXT(a_ro_start, store_ctl.start, ro_active_reg && in_stall)

endmodule
